// ----- rtl/i2cdw_pkg.sv -----
// ----------------------------------------------------------------------------
// I2C display write master: shared definitions
// Bus phase codes, register indexes, reset values and the item structs
// used by the engine, the output register and the top level.
// ----------------------------------------------------------------------------
package i2cdw_pkg;

   // Configuration register indexes.
   localparam logic CSR_DEVICE_ADDRESS = 1'b0;
   localparam logic CSR_PHASE_TICKS    = 1'b1;

   // Configuration reset values.
   localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'h78;
   localparam logic [7:0] PHASE_TICKS_RESET    = 8'h01;

   // Control bytes sent after the address byte.
   localparam logic [7:0] CTRL_COMMAND = 8'h00;
   localparam logic [7:0] CTRL_DATA    = 8'h40;

   // Bits in one byte, and the byte index that selects the control byte.
   localparam logic [3:0] BITS_PER_BYTE = 4'd8;
   localparam logic [1:0] CTRL_BYTE_IDX = 2'd1;
   localparam logic [1:0] LAST_BYTE_IDX = 2'd2;

   // Bus phases, one-hot.
   typedef enum logic [13:0] {
      PH_IDLE      = 14'b00000000000001,
      PH_START_HI  = 14'b00000000000010,
      PH_START_LO  = 14'b00000000000100,
      PH_START_CLK = 14'b00000000001000,
      PH_BIT_SET   = 14'b00000000010000,
      PH_BIT_HIGH  = 14'b00000000100000,
      PH_BIT_LOW   = 14'b00000001000000,
      PH_ACK_REL   = 14'b00000010000000,
      PH_ACK_HIGH  = 14'b00000100000000,
      PH_ACK_OK    = 14'b00001000000000,
      PH_ACK_RETRY = 14'b00010000000000,
      PH_STOP_LO   = 14'b00100000000000,
      PH_STOP_CLK  = 14'b01000000000000,
      PH_STOP_REL  = 14'b10000000000000
   } phase_type;

   // Configuration seen by the engine.
   typedef struct packed {
      logic [7:0] device_address;
      logic [7:0] phase_ticks;
   } cfg_type;

   // One input item (one tick).
   typedef struct packed {
      logic       start_request;
      logic       req_type;
      logic [7:0] payload;
      logic       sda_in;
   } item_type;

   // One result item.
   typedef struct packed {
      logic scl_out;
      logic sda_out;
      logic busy_res;
      logic done_res;
   } result_type;

endpackage

// ----- rtl/i2cdw_if.sv -----
// ----------------------------------------------------------------------------
// I2C display write master: channel interfaces
// Valid/ready channels for the tick items and for the bus level results.
// ----------------------------------------------------------------------------
interface i2cdw_req_if;
   logic       valid;
   logic       ready;
   logic       start_request;
   logic       req_type;
   logic [7:0] payload;
   logic       sda_in;

   modport source (output valid, start_request, req_type, payload, sda_in, input ready);
   modport sink   (input valid, start_request, req_type, payload, sda_in, output ready);
endinterface

interface i2cdw_rsp_if;
   logic valid;
   logic ready;
   logic scl_out;
   logic sda_out;
   logic busy_res;
   logic done_res;

   modport source (output valid, scl_out, sda_out, busy_res, done_res, input ready);
   modport sink   (input valid, scl_out, sda_out, busy_res, done_res, output ready);
endinterface

// ----- rtl/i2cdw_engine.sv -----
// ----------------------------------------------------------------------------
// I2C display write master: transaction engine
// Holds the bus phase state and advances it by one tick for every accepted
// item, producing the SCL/SDA levels and status for that tick.
// ----------------------------------------------------------------------------
module i2cdw_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  i2cdw_pkg::cfg_type     cfg,
   input  i2cdw_pkg::item_type    item,
   output i2cdw_pkg::result_type  result
);

   i2cdw_pkg::phase_type phase_ff, phase_in, phase_cur;
   logic [1:0] byte_index_ff, byte_index_in, byte_index_cur, byte_next;
   logic [3:0] bit_count_ff, bit_count_in, bit_count_cur, bit_next;
   logic [7:0] tick_count_ff, tick_count_in, tick_next;
   logic [7:0] shift_byte_ff, shift_byte_in;
   logic [7:0] held_payload_ff, held_payload_in;
   logic       held_type_ff, held_type_in;
   logic [7:0] limit;
   logic       idle_now;
   logic       data_bit;
   logic       scl_level, sda_level;
   logic       busy, done;

   // A phase time of zero counts as one tick.
   assign limit = (cfg.phase_ticks == 8'd0) ? 8'd1 : cfg.phase_ticks;

   always_comb begin
      phase_cur       = phase_ff;
      byte_index_cur  = byte_index_ff;
      bit_count_cur   = bit_count_ff;
      tick_count_in   = tick_count_ff;
      shift_byte_in   = shift_byte_ff;
      held_payload_in = held_payload_ff;
      held_type_in    = held_type_ff;
      done            = 1'b0;
      byte_next       = byte_index_ff + 2'd1;
      bit_next        = bit_count_ff + 4'd1;
      tick_next       = tick_count_ff + 8'd1;

      // Unknown phase codes behave as idle.
      case (phase_ff)
         i2cdw_pkg::PH_START_HI, i2cdw_pkg::PH_START_LO, i2cdw_pkg::PH_START_CLK,
         i2cdw_pkg::PH_BIT_SET, i2cdw_pkg::PH_BIT_HIGH, i2cdw_pkg::PH_BIT_LOW,
         i2cdw_pkg::PH_ACK_REL, i2cdw_pkg::PH_ACK_HIGH, i2cdw_pkg::PH_ACK_OK,
         i2cdw_pkg::PH_ACK_RETRY, i2cdw_pkg::PH_STOP_LO, i2cdw_pkg::PH_STOP_CLK,
         i2cdw_pkg::PH_STOP_REL: begin
            idle_now = 1'b0;
         end
         default: begin
            idle_now = 1'b1;
         end
      endcase

      // A request while idle starts a transaction on this same tick.
      if (idle_now) begin
         phase_cur = i2cdw_pkg::PH_IDLE;
         if (item.start_request) begin
            held_payload_in = item.payload;
            held_type_in    = item.req_type;
            byte_index_cur  = 2'd0;
            bit_count_cur   = 4'd0;
            tick_count_in   = 8'd0;
            shift_byte_in   = cfg.device_address;
            phase_cur       = i2cdw_pkg::PH_START_HI;
            tick_next       = 8'd1;
            byte_next       = 2'd1;
            bit_next        = 4'd1;
         end
      end

      data_bit = shift_byte_in[7];

      // Bus levels for the phase of this tick.
      case (phase_cur)
         i2cdw_pkg::PH_START_HI:  begin scl_level = 1'b1; sda_level = 1'b1;     end
         i2cdw_pkg::PH_START_LO:  begin scl_level = 1'b1; sda_level = 1'b0;     end
         i2cdw_pkg::PH_START_CLK: begin scl_level = 1'b0; sda_level = 1'b0;     end
         i2cdw_pkg::PH_BIT_SET:   begin scl_level = 1'b0; sda_level = data_bit; end
         i2cdw_pkg::PH_BIT_HIGH:  begin scl_level = 1'b1; sda_level = data_bit; end
         i2cdw_pkg::PH_BIT_LOW:   begin scl_level = 1'b0; sda_level = data_bit; end
         i2cdw_pkg::PH_ACK_REL:   begin scl_level = 1'b0; sda_level = 1'b1;     end
         i2cdw_pkg::PH_ACK_HIGH:  begin scl_level = 1'b1; sda_level = 1'b1;     end
         i2cdw_pkg::PH_ACK_OK:    begin scl_level = 1'b0; sda_level = 1'b1;     end
         i2cdw_pkg::PH_ACK_RETRY: begin scl_level = 1'b0; sda_level = 1'b1;     end
         i2cdw_pkg::PH_STOP_LO:   begin scl_level = 1'b0; sda_level = 1'b0;     end
         i2cdw_pkg::PH_STOP_CLK:  begin scl_level = 1'b1; sda_level = 1'b0;     end
         i2cdw_pkg::PH_STOP_REL:  begin scl_level = 1'b1; sda_level = 1'b1;     end
         default:                 begin scl_level = 1'b1; sda_level = 1'b1;     end
      endcase

      busy          = (phase_cur != i2cdw_pkg::PH_IDLE);
      phase_in      = phase_cur;
      byte_index_in = byte_index_cur;
      bit_count_in  = bit_count_cur;

      // Count ticks in the phase and move on when it has lasted long enough.
      if (!busy) begin
         tick_count_in = 8'd0;
      end else if (tick_next >= limit) begin
         tick_count_in = 8'd0;
         case (phase_cur)
            i2cdw_pkg::PH_START_HI:  phase_in = i2cdw_pkg::PH_START_LO;
            i2cdw_pkg::PH_START_LO:  phase_in = i2cdw_pkg::PH_START_CLK;
            i2cdw_pkg::PH_START_CLK: begin
               bit_count_in = 4'd0;
               phase_in     = i2cdw_pkg::PH_BIT_SET;
            end
            i2cdw_pkg::PH_BIT_SET:   phase_in = i2cdw_pkg::PH_BIT_HIGH;
            i2cdw_pkg::PH_BIT_HIGH:  phase_in = i2cdw_pkg::PH_BIT_LOW;
            i2cdw_pkg::PH_BIT_LOW: begin
               shift_byte_in = {shift_byte_in[6:0], 1'b0};
               bit_count_in  = bit_next;
               phase_in      = (bit_next >= i2cdw_pkg::BITS_PER_BYTE) ?
                               i2cdw_pkg::PH_ACK_REL : i2cdw_pkg::PH_BIT_SET;
            end
            i2cdw_pkg::PH_ACK_REL:   phase_in = i2cdw_pkg::PH_ACK_HIGH;
            i2cdw_pkg::PH_ACK_HIGH:  phase_in = item.sda_in ?
                                                i2cdw_pkg::PH_ACK_RETRY : i2cdw_pkg::PH_ACK_OK;
            i2cdw_pkg::PH_ACK_RETRY: phase_in = i2cdw_pkg::PH_ACK_REL;
            i2cdw_pkg::PH_ACK_OK: begin
               byte_index_in = byte_next;
               if (byte_next > i2cdw_pkg::LAST_BYTE_IDX || byte_next == 2'd0) begin
                  phase_in = i2cdw_pkg::PH_STOP_LO;
               end else begin
                  if (byte_next == i2cdw_pkg::CTRL_BYTE_IDX) begin
                     shift_byte_in = held_type_in ? i2cdw_pkg::CTRL_DATA
                                                  : i2cdw_pkg::CTRL_COMMAND;
                  end else begin
                     shift_byte_in = held_payload_in;
                  end
                  bit_count_in = 4'd0;
                  phase_in     = i2cdw_pkg::PH_BIT_SET;
               end
            end
            i2cdw_pkg::PH_STOP_LO:   phase_in = i2cdw_pkg::PH_STOP_CLK;
            i2cdw_pkg::PH_STOP_CLK:  phase_in = i2cdw_pkg::PH_STOP_REL;
            i2cdw_pkg::PH_STOP_REL: begin
               phase_in      = i2cdw_pkg::PH_IDLE;
               byte_index_in = 2'd0;
               bit_count_in  = 4'd0;
               done          = 1'b1;
            end
            default:                 phase_in = i2cdw_pkg::PH_IDLE;
         endcase
      end else begin
         tick_count_in = tick_next;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= i2cdw_pkg::PH_IDLE;
         byte_index_ff <= 2'd0;
         bit_count_ff  <= 4'd0;
         tick_count_ff <= 8'd0;
         held_type_ff  <= 1'b0;
      end else if (step) begin
         phase_ff      <= phase_in;
         byte_index_ff <= byte_index_in;
         bit_count_ff  <= bit_count_in;
         tick_count_ff <= tick_count_in;
         held_type_ff  <= held_type_in;
      end
   end

   // Data held for the transaction.
   always_ff @(posedge clock) begin
      if (step) begin
         shift_byte_ff   <= shift_byte_in;
         held_payload_ff <= held_payload_in;
      end
   end

   assign result.scl_out  = scl_level;
   assign result.sda_out  = sda_level;
   assign result.busy_res = busy;
   assign result.done_res = done;

endmodule

// ----- rtl/i2cdw_out_reg.sv -----
// ----------------------------------------------------------------------------
// I2C display write master: result register
// Holds one result item until the receiver takes it, and tells the input
// side when a new item may be taken.
// ----------------------------------------------------------------------------
module i2cdw_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  i2cdw_pkg::result_type data,
   input  logic                  out_ready,
   output logic                  can_load,
   output logic                  out_valid,
   output i2cdw_pkg::result_type out_data
);

   logic                  valid_ff, valid_in;
   i2cdw_pkg::result_type data_ff;

   // A new item may enter when the register is empty or is drained this cycle.
   assign can_load = !valid_ff || out_ready;
   assign valid_in = load || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- rtl/i2c_display_write_master_core.sv -----
// ----------------------------------------------------------------------------
// I2C display write master
// Runs an I2C write of address, control byte and payload, one tick per item.
// ----------------------------------------------------------------------------
// Usage:
//   Every item on req is one bus tick: it carries the sampled SDA level and,
//   when the master is idle, an optional request to write one byte as a
//   command or as display data. Every accepted item yields exactly one item
//   on rsp with the SCL and SDA levels to drive for that tick, a busy flag
//   and a done pulse on the last tick of the stop condition.
//   The result of an item is in the output register the cycle after it is
//   accepted. Throughput is one item per cycle while the receiver takes each
//   result; the phase state is updated in a single pass from the input item.
//   req.ready is high whenever the output register is empty or is being
//   read, so a stalled receiver stalls the input side after one item.
//   Reset returns the master to idle with device_address 0x78 and one tick
//   per phase, and empties the output register.
//   csr writes are taken in any cycle but are meant for idle periods.
// ----------------------------------------------------------------------------
module i2c_display_write_master_core (
   input  logic         clock,
   input  logic         reset,
   i2cdw_req_if.sink    req,
   i2cdw_rsp_if.source  rsp,
   input  logic         csr_wr_en,
   input  logic         csr_index,
   input  logic [7:0]   csr_wdata
);

   logic [7:0]            device_address_ff;
   logic [7:0]            phase_ticks_ff;
   i2cdw_pkg::cfg_type    cfg;
   i2cdw_pkg::item_type   item;
   i2cdw_pkg::result_type result;
   i2cdw_pkg::result_type out_data;
   logic                  can_load;
   logic                  fire;
   logic                  out_valid;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff <= i2cdw_pkg::DEVICE_ADDRESS_RESET;
         phase_ticks_ff    <= i2cdw_pkg::PHASE_TICKS_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            i2cdw_pkg::CSR_DEVICE_ADDRESS: device_address_ff <= csr_wdata;
            i2cdw_pkg::CSR_PHASE_TICKS:    phase_ticks_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign cfg.device_address = device_address_ff;
   assign cfg.phase_ticks    = phase_ticks_ff;

   // Input handshake.
   assign req.ready          = can_load;
   assign fire               = req.valid && can_load;
   assign item.start_request = req.start_request;
   assign item.req_type      = req.req_type;
   assign item.payload       = req.payload;
   assign item.sda_in        = req.sda_in;

   i2cdw_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (fire),
      .cfg    (cfg),
      .item   (item),
      .result (result)
   );

   i2cdw_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (fire),
      .data      (result),
      .out_ready (rsp.ready),
      .can_load  (can_load),
      .out_valid (out_valid),
      .out_data  (out_data)
   );

   // Result channel.
   assign rsp.valid    = out_valid;
   assign rsp.scl_out  = out_data.scl_out;
   assign rsp.sda_out  = out_data.sda_out;
   assign rsp.busy_res = out_data.busy_res;
   assign rsp.done_res = out_data.done_res;

   // The stop condition only completes inside a transaction.
   a_done_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.done_res |-> rsp.busy_res)
      else $error("done reported outside a transaction");

   // An idle tick leaves both bus lines released.
   a_idle_released: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.busy_res |-> rsp.scl_out && rsp.sda_out)
      else $error("bus line driven low while idle");

   // Each accepted item leaves a result in the output register.
   a_fire_fills: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp.valid)
      else $error("accepted item produced no result");

   // A done tick drives the stop release levels.
   a_done_levels: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.done_res |-> rsp.scl_out && rsp.sda_out)
      else $error("done without stop release levels");

endmodule
